>>> sv/csq_pkg.sv
// csq_pkg: shared constants, codes, control structs and a helper function
// for the semaphore wait-queue unit. No dependencies; every other file
// imports it.
package csq_pkg;

  // default configuration
  localparam int NUM_RES_DEF     = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int PID_BITS_DEF    = 16;

  // request / result field widths
  localparam int FUNC_W     = 2;
  localparam int RES_IDX_W  = 4;
  localparam int PID_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int DEF_W      = 5;

  // counter
  localparam int CNT_W      = 10;
  localparam int CNT_MAX    = (2 ** (CNT_W - 1)) - 1;
  localparam int CNT_MIN    = -(2 ** (CNT_W - 1));
  localparam int DEF_MAX    = (2 ** DEF_W) - 1;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int DEFRES_W   = 3;
  localparam int QTY_W      = 8;
  localparam int MAX_QTY_REGS = 4;

  localparam logic [CFG_IDX_W-1:0] REG_DEFINED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_R0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LAST = 3'd4;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_WAIT   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SIGNAL = 2'd1;
  localparam logic [FUNC_W-1:0] FN_POP    = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BLOCKED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNDEF   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERMAX = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;

  // counter preload request from the register block
  typedef struct packed {
    logic                en;
    logic [DEFRES_W-1:0] res;
    logic [QTY_W-1:0]    value;
  } csq_load_t;

  // state memory port control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic cnt_only;   // write the counter field alone
  } csq_state_ctl_t;

  // waiter store port control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } csq_wait_ctl_t;

  // magnitude of a non-positive counter, clipped to the field
  function automatic logic [DEF_W-1:0] deficit_of(input logic signed [CNT_W:0] v);
    logic signed [CNT_W:0] neg;
    neg = -v;
    if (v >= 0) begin
      deficit_of = '0;
    end else if (v < -DEF_MAX) begin
      deficit_of = DEF_W'(DEF_MAX);
    end else begin
      deficit_of = neg[DEF_W-1:0];
    end
  endfunction

endpackage

>>> sv/csq_if.sv
// csq_if: valid/ready channel interfaces for the operation requests and
// the result requests. Depends on csq_pkg.
interface csq_op_if;
  import csq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [RES_IDX_W-1:0] resource_index;
  logic [PID_W-1:0]     proc_id;

  modport source (output valid, output func, output resource_index, output proc_id,
                  input ready);
  modport sink   (input valid, input func, input resource_index, input proc_id,
                  output ready);
endinterface

interface csq_result_if;
  import csq_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DEF_W-1:0]    deficit;
  logic [PID_W-1:0]    popped_pid;

  modport source (output valid, output status, output deficit, output popped_pid,
                  input ready);
  modport sink   (input valid, input status, input deficit, input popped_pid,
                  output ready);
endinterface

>>> sv/csq_cfg.sv
// csq_cfg: APB-style register block (resource count, per-resource maxima)
// and the counter preload request. Depends on csq_pkg.
module csq_cfg #(
  parameter int NUM_RES = csq_pkg::NUM_RES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [csq_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [csq_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [csq_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                  pready,
  output logic [csq_pkg::DEFRES_W-1:0]          defined_resources,
  output logic [NUM_RES-1:0][csq_pkg::QTY_W-1:0] max_qty,
  output csq_pkg::csq_load_t                    load
);
  import csq_pkg::*;

  logic [CFG_IDX_W-1:0] idx;
  logic                 wr;

  assign idx    = paddr[CFG_IDX_W+1:2];
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      defined_resources <= '0;
      max_qty           <= '0;
    end else if (wr) begin
      if (idx == REG_DEFINED) begin
        defined_resources <= pwdata[DEFRES_W-1:0];
      end
      for (int r = 0; r < NUM_RES; r++) begin
        if (r < MAX_QTY_REGS && idx == CFG_IDX_W'(int'(REG_MAX_R0) + r)) begin
          max_qty[r] <= pwdata[QTY_W-1:0];
        end
      end
    end
  end

  // a maximum write also reloads that resource's counter
  always_comb begin
    load.en    = 1'b0;
    load.res   = idx - REG_MAX_R0;
    load.value = pwdata[QTY_W-1:0];
    if (wr && idx >= REG_MAX_R0 && idx <= REG_MAX_LAST &&
        (idx - REG_MAX_R0) < CFG_IDX_W'(NUM_RES)) begin
      load.en = 1'b1;
    end
  end

  always_comb begin
    prdata = '0;
    if (idx == REG_DEFINED) begin
      prdata = CFG_DATA_W'(defined_resources);
    end
    for (int r = 0; r < NUM_RES; r++) begin
      if (r < MAX_QTY_REGS && idx == CFG_IDX_W'(int'(REG_MAX_R0) + r)) begin
        prdata = CFG_DATA_W'(max_qty[r]);
      end
    end
  end

endmodule

>>> sv/csq_state_mem.sv
// csq_state_mem: per-resource state memory {counter, head, fill}, one read
// and one write port, registered read, field write enable. Depends on csq_pkg.
module csq_state_mem #(
  parameter int NUM_RES     = csq_pkg::NUM_RES_DEF,
  parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF,
  localparam int RES_AW     = (NUM_RES > 1) ? $clog2(NUM_RES) : 1,
  localparam int QA         = $clog2(QUEUE_DEPTH),
  localparam int QF         = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  csq_pkg::csq_state_ctl_t            ctl,
  input  logic [RES_AW-1:0]                  rd_addr,
  input  logic [RES_AW-1:0]                  wr_addr,
  input  logic signed [csq_pkg::CNT_W-1:0]   wr_cnt,
  input  logic [QA-1:0]                      wr_head,
  input  logic [QF-1:0]                      wr_fill,
  output logic signed [csq_pkg::CNT_W-1:0]   rd_cnt,
  output logic [QA-1:0]                      rd_head,
  output logic [QF-1:0]                      rd_fill
);
  import csq_pkg::*;

  logic [CNT_W-1:0]   cnt_mem [NUM_RES];
  logic [QA+QF-1:0]   ptr_mem [NUM_RES];
  logic [NUM_RES-1:0] cnt_vld;
  logic [NUM_RES-1:0] ptr_vld;

  logic [CNT_W-1:0] cnt_q;
  logic [QA+QF-1:0] ptr_q;
  logic             cnt_vq;
  logic             ptr_vq;

  // entries not yet written read as the reset value (zero)
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld <= '0;
      ptr_vld <= '0;
    end else if (ctl.wr_en) begin
      cnt_vld[wr_addr] <= 1'b1;
      if (!ctl.cnt_only) begin
        ptr_vld[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      cnt_mem[wr_addr] <= wr_cnt;
      if (!ctl.cnt_only) begin
        ptr_mem[wr_addr] <= {wr_head, wr_fill};
      end
    end
    if (ctl.rd_en) begin
      cnt_q  <= cnt_mem[rd_addr];
      ptr_q  <= ptr_mem[rd_addr];
      cnt_vq <= cnt_vld[rd_addr];
      ptr_vq <= ptr_vld[rd_addr];
    end
  end

  assign rd_cnt  = cnt_vq ? cnt_q : '0;
  assign rd_head = ptr_vq ? ptr_q[QA+QF-1:QF] : '0;
  assign rd_fill = ptr_vq ? ptr_q[QF-1:0] : '0;

endmodule

>>> sv/csq_waiter_mem.sv
// csq_waiter_mem: store of blocked process ids, one ring per resource,
// single write and single registered read port. Depends on csq_pkg.
module csq_waiter_mem #(
  parameter int NUM_RES     = csq_pkg::NUM_RES_DEF,
  parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF,
  parameter int DATA_W      = csq_pkg::PID_W,
  localparam int RES_AW     = (NUM_RES > 1) ? $clog2(NUM_RES) : 1,
  localparam int QA         = $clog2(QUEUE_DEPTH)
) (
  input  logic                  clk,
  input  csq_pkg::csq_wait_ctl_t ctl,
  input  logic [RES_AW-1:0]     wr_res,
  input  logic [QA-1:0]         wr_slot,
  input  logic [DATA_W-1:0]     wr_data,
  input  logic [RES_AW-1:0]     rd_res,
  input  logic [QA-1:0]         rd_slot,
  output logic [DATA_W-1:0]     rd_data
);
  import csq_pkg::*;

  logic [DATA_W-1:0] mem [NUM_RES][QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_res][wr_slot] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_res][rd_slot];
    end
  end

endmodule

>>> sv/counting_semaphore_wait_queue_unit.sv
// counting_semaphore_wait_queue_unit: top level of the semaphore bank,
// sequencer and result register. Depends on csq_pkg, csq_if, csq_cfg,
// csq_state_mem and csq_waiter_mem.
//
// A bank of NUM_RES counting semaphores, each with a FIFO of up to
// QUEUE_DEPTH blocked process ids. Requests arrive on op (wait, signal or
// pop the oldest waiter) and each gives exactly one result request on
// result. One request is in work at a time: a wait, a signal, a pop with
// no waiter, an undefined resource or an unused code goes through the state
// memory read and then the update and any write-back; a pop that finds a waiter
// adds a waiter store read after the update, because the waiter store is
// addressed by the head pointer that the state memory read returns. op.ready
// drops until the result is loaded. The result sits in an output register,
// so a new request is taken while an earlier result still waits for
// result.ready; the update of the following request is held until that
// register is free. Counters, heads and fills start at zero after reset
// (valid bits, no clearing pass). Writing max_qty_rN loads counter N with
// the value and leaves its queue as is. The user must write registers over
// the APB port only while no request is in work; the block does not enforce it.

module counting_semaphore_wait_queue_unit #(
  parameter int NUM_RES     = csq_pkg::NUM_RES_DEF,
  parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF,
  parameter int PID_BITS    = csq_pkg::PID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  csq_op_if.sink                         op,
  csq_result_if.source                   result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [csq_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [csq_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [csq_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import csq_pkg::*;

  localparam int RES_AW = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
  localparam int QA     = $clog2(QUEUE_DEPTH);
  localparam int QF     = $clog2(QUEUE_DEPTH + 1);
  // stored pid width: the pid field is never wider than the port
  localparam int PW     = (PID_BITS < PID_W) ? PID_BITS : PID_W;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_POP} seq_state_t;

  seq_state_t state;

  // configuration
  logic [DEFRES_W-1:0]          defined_resources;
  logic [NUM_RES-1:0][QTY_W-1:0] max_qty;
  csq_load_t                    load;

  // request held for the update
  logic [FUNC_W-1:0]    func_q;
  logic [RES_IDX_W-1:0] res_q;
  logic [PID_W-1:0]     pid_q;

  // result register
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [DEF_W-1:0]    out_deficit;
  logic [PID_W-1:0]    out_pid;

  // memory ports
  csq_state_ctl_t     st_ctl;
  logic [RES_AW-1:0]  st_wr_addr;
  logic signed [CNT_W-1:0] st_wr_cnt;
  logic signed [CNT_W-1:0] upd_cnt;
  logic [QA-1:0]      st_wr_head;
  logic [QF-1:0]      st_wr_fill;
  logic signed [CNT_W-1:0] rd_cnt;
  logic [QA-1:0]      rd_head;
  logic [QF-1:0]      rd_fill;

  csq_wait_ctl_t      wt_ctl;
  logic [QA-1:0]      wt_slot;
  logic [PW-1:0]      wt_rd_data;

  // sequencer
  logic                accept;
  logic                out_free;
  logic                go;
  logic [RES_AW-1:0]   res_idx;
  logic                defined;
  logic                step_wr;
  logic                ld_out;
  logic                to_pop;
  logic [STATUS_W-1:0] nx_status;
  logic [DEF_W-1:0]    nx_deficit;
  logic [PID_W-1:0]    nx_pid;

  // arithmetic
  logic signed [CNT_W:0] c_ext;
  logic signed [CNT_W:0] dec;
  logic signed [CNT_W:0] inc;
  logic signed [CNT_W:0] dec_sat;
  logic signed [CNT_W:0] inc_sat;
  logic signed [CNT_W:0] max_ext;
  logic [QF:0]           tail_sum;
  logic [QA-1:0]         tail_slot;
  logic [QA:0]           head_inc;
  logic [QA-1:0]         head_nx;

  csq_cfg #(.NUM_RES(NUM_RES)) u_cfg (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .defined_resources (defined_resources),
    .max_qty           (max_qty),
    .load              (load)
  );

  csq_state_mem #(.NUM_RES(NUM_RES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_state_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (st_ctl),
    .rd_addr (op.resource_index[RES_AW-1:0]),
    .wr_addr (st_wr_addr),
    .wr_cnt  (st_wr_cnt),
    .wr_head (st_wr_head),
    .wr_fill (st_wr_fill),
    .rd_cnt  (rd_cnt),
    .rd_head (rd_head),
    .rd_fill (rd_fill)
  );

  csq_waiter_mem #(.NUM_RES(NUM_RES), .QUEUE_DEPTH(QUEUE_DEPTH), .DATA_W(PW)) u_waiter_mem (
    .clk     (clk),
    .ctl     (wt_ctl),
    .wr_res  (res_idx),
    .wr_slot (wt_slot),
    .wr_data (pid_q[PW-1:0]),
    .rd_res  (res_idx),
    .rd_slot (wt_slot),
    .rd_data (wt_rd_data)
  );

  assign op.ready = (state == S_IDLE);
  assign accept   = op.valid && op.ready;
  assign out_free = !out_valid || result.ready;
  // update step waits for a free result register; read data stays put
  assign go       = (state == S_EXEC) && out_free;
  assign res_idx  = res_q[RES_AW-1:0];
  assign defined  = (func_q <= FN_POP) &&
                    (res_q < RES_IDX_W'(defined_resources)) &&
                    (res_q < RES_IDX_W'(NUM_RES));

  // counter arithmetic, one bit wider so the limits can be seen
  always_comb begin
    c_ext   = {rd_cnt[CNT_W-1], rd_cnt};
    dec     = c_ext - (CNT_W+1)'(1);
    inc     = c_ext + (CNT_W+1)'(1);
    dec_sat = (dec < CNT_MIN) ? (CNT_W+1)'(CNT_MIN) : dec;
    inc_sat = (inc > CNT_MAX) ? (CNT_W+1)'(CNT_MAX) : inc;
    max_ext = (CNT_W+1)'(max_qty[res_idx]);
    // tail slot = (head + fill) mod depth; the sum stays below twice the depth
    tail_sum  = (QF+1)'(rd_head) + (QF+1)'(rd_fill);
    tail_slot = (tail_sum >= (QF+1)'(QUEUE_DEPTH)) ?
                QA'(tail_sum - (QF+1)'(QUEUE_DEPTH)) : QA'(tail_sum);
    head_inc  = (QA+1)'(rd_head) + (QA+1)'(1);
    head_nx   = (head_inc == (QA+1)'(QUEUE_DEPTH)) ? '0 : QA'(head_inc);
  end

  // update step: result fields and write-back
  always_comb begin
    nx_status  = ST_UNDEF;
    nx_deficit = '0;
    nx_pid     = '0;
    step_wr    = 1'b0;
    to_pop     = 1'b0;
    upd_cnt    = rd_cnt;
    st_wr_head = rd_head;
    st_wr_fill = rd_fill;
    wt_ctl     = '0;
    wt_slot    = rd_head;

    if (defined) begin
      case (func_q)
        FN_WAIT: begin
          if (dec >= 0) begin
            nx_status = ST_OK;
            upd_cnt   = dec[CNT_W-1:0];
            step_wr   = 1'b1;
          end else if (rd_fill >= QF'(QUEUE_DEPTH)) begin
            // queue full: counter left as it is
            nx_status  = ST_FULL;
            nx_deficit = deficit_of(c_ext);
          end else begin
            nx_status    = ST_BLOCKED;
            nx_deficit   = deficit_of(dec_sat);
            upd_cnt      = dec_sat[CNT_W-1:0];
            st_wr_fill   = rd_fill + QF'(1);
            step_wr      = 1'b1;
            wt_ctl.wr_en = go;
            wt_slot      = tail_slot;
          end
        end
        FN_SIGNAL: begin
          upd_cnt   = inc_sat[CNT_W-1:0];
          step_wr   = 1'b1;
          if (inc_sat > max_ext) begin
            nx_status = ST_OVERMAX;
          end else begin
            nx_status  = ST_OK;
            nx_deficit = deficit_of(inc_sat);
          end
        end
        FN_POP: begin
          if (rd_fill == '0) begin
            nx_status = ST_NONE;
          end else begin
            // result comes from the waiter store in the next cycle, in S_POP
            nx_status    = ST_OK;
            st_wr_head   = head_nx;
            st_wr_fill   = rd_fill - QF'(1);
            step_wr      = 1'b1;
            to_pop       = 1'b1;
            wt_ctl.rd_en = go;
          end
        end
        default: begin
          nx_status = ST_UNDEF;
        end
      endcase
    end

    if (state == S_POP) begin
      nx_status  = ST_OK;
      nx_deficit = '0;
      nx_pid     = PID_W'(wt_rd_data);
    end
  end

  // result register free at S_EXEC stays free through S_POP
  assign ld_out = (go && !to_pop) || (state == S_POP);

  // state memory: the update step and the counter preload share the write
  // port, update first; the user is to change registers only while idle (not enforced)
  always_comb begin
    st_ctl.rd_en    = accept && (op.resource_index < RES_IDX_W'(NUM_RES));
    st_ctl.wr_en    = (go && step_wr) || load.en;
    st_ctl.cnt_only = !(go && step_wr);
    st_wr_addr      = (go && step_wr) ? res_idx : load.res[RES_AW-1:0];
    st_wr_cnt       = upd_cnt;
    if (!(go && step_wr)) begin
      st_wr_cnt  = CNT_W'(load.value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (go) begin
            state <= to_pop ? S_POP : S_IDLE;
          end
        end
        S_POP: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (ld_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      func_q <= op.func;
      res_q  <= op.resource_index;
      pid_q  <= op.proc_id;
    end
    if (ld_out) begin
      out_status  <= nx_status;
      out_deficit <= nx_deficit;
      out_pid     <= nx_pid;
    end
  end

  assign result.valid      = out_valid;
  assign result.status     = out_status;
  assign result.deficit    = out_deficit;
  assign result.popped_pid = out_pid;

endmodule

>>> sv/csq_checker.sv
// csq_checker: port-level assertions for the semaphore wait-queue unit,
// and the bind that attaches them to the top level. Depends on csq_pkg.
module csq_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         op_valid,
  input logic                         op_ready,
  input logic                         result_valid,
  input logic                         result_ready,
  input logic [csq_pkg::STATUS_W-1:0] status,
  input logic [csq_pkg::DEF_W-1:0]    deficit,
  input logic [csq_pkg::PID_W-1:0]    popped_pid
);
  import csq_pkg::*;

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(status) && $stable(deficit) && $stable(popped_pid))
    else $error("result changed while stalled");

  // one request in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    op_valid && op_ready |=> !op_ready)
    else $error("request taken while another is in work");

  // a pid is only returned by a successful pop
  a_pid_on_pop: assert property (@(posedge clk) disable iff (rst)
    result_valid && popped_pid != '0 |-> status == ST_OK && deficit == '0)
    else $error("popped pid with wrong status or deficit");

  // undefined, none waiting and over maximum carry empty fields
  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_UNDEF || status == ST_NONE || status == ST_OVERMAX)
      |-> deficit == '0 && popped_pid == '0)
    else $error("non-zero fields on an error status");

  // no result straight after reset
  a_reset_clean: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule

bind counting_semaphore_wait_queue_unit csq_checker u_csq_checker (
  .clk          (clk),
  .rst          (rst),
  .op_valid     (op.valid),
  .op_ready     (op.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .status       (result.status),
  .deficit      (result.deficit),
  .popped_pid   (result.popped_pid)
);
